/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro takes a label, the clock,
// the active-low reset, a condition and the property that must follow.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

/* rtl/acp_pkg.sv */
package acp_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] action_t;
	typedef logic [6:0] attr_t;
	typedef logic [9:0] param_t;

	localparam int unsigned DEFAULT_MAX_PARAMS = 8;

	localparam action_t ACT_PRINT     = 3'd0;
	localparam action_t ACT_BACKSPACE = 3'd1;
	localparam action_t ACT_SET_ATTR  = 3'd2;
	localparam action_t ACT_CLEAR     = 3'd3;
	localparam action_t ACT_CURSOR    = 3'd4;

	localparam byte_t CH_ESC       = 8'h1B;
	localparam byte_t CH_BACKSPACE = 8'h08;
	localparam byte_t CH_BRACKET   = 8'h5B;
	localparam byte_t CH_GREATER   = 8'h3E;
	localparam byte_t CH_SEMICOLON = 8'h3B;
	localparam byte_t CH_ZERO      = 8'h30;
	localparam byte_t CH_NINE      = 8'h39;
	localparam byte_t CH_LOWER_M   = 8'h6D;
	localparam byte_t CH_UPPER_J   = 8'h4A;
	localparam byte_t CH_LOWER_L   = 8'h6C;

	localparam attr_t  ATTR_RESET = 7'd7;
	localparam param_t SAT_LIMIT  = 10'd999;
	// All ones never occurs as a value, so it marks an empty parameter.
	localparam param_t PARAM_EMPTY = 10'h3FF;

	localparam param_t SGR_RESET  = 10'd0;
	localparam param_t SGR_BRIGHT = 10'd1;
	localparam param_t SGR_FG_LO  = 10'd30;
	localparam param_t SGR_FG_HI  = 10'd37;
	localparam param_t SGR_BG_LO  = 10'd40;
	localparam param_t SGR_BG_HI  = 10'd47;

	function automatic logic [2:0] bgr_to_rgb(input logic [2:0] c);
		logic [2:0] r;
		unique case (c)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	function automatic logic is_alpha(input byte_t c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

/* rtl/acp_in_if.sv */
interface acp_in_if;
	import acp_pkg::*;

	logic  valid;
	logic  ready;
	byte_t byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

/* rtl/acp_out_if.sv */
interface acp_out_if;
	import acp_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	byte_t   out_byte;
	attr_t   attribute;

	modport source (output valid, output action, output out_byte, output attribute,
		input ready);
	modport sink (input valid, input action, input out_byte, input attribute,
		output ready);
endinterface

/* rtl/ansi_escape_color_parser_top.sv */
// Console escape parser. Bytes arrive on in_ch, one per transfer; each byte
// gives zero or one console action on out_ch (print, backspace, set
// attribute, clear screen, cursor refresh), together with the colour
// attribute as it stands after that byte.
// An ordinary byte's action is in the output register in the cycle after
// the byte is taken. The SGR terminator 'm' walks the stored parameters
// through one shared compare-and-update unit, one parameter slot per cycle,
// over each slot in use (at most MAX_PARAMS); the EMIT state then loads the
// result into the output register, and no further byte is taken before
// that. in_ch.ready is low during the walk.
// The output register holds one result. A new byte is taken while a result
// waits only if out_ch takes that result in the same cycle; when the
// receiver stalls with a full register, in_ch.ready stays low until the
// transfer happens.
// Reset puts the block in printing mode with the attribute white on black
// (7) and the output register empty. The parameter store is not reset.
// The '[' mark has no effect on any action, so the byte is simply consumed.
module ansi_escape_color_parser_top #(
	parameter int unsigned MAX_PARAMS = acp_pkg::DEFAULT_MAX_PARAMS
) (
	input  logic            clk,
	input  logic            arst_n,
	acp_in_if.sink          in_ch,
	acp_out_if.source       out_ch
);
	import acp_pkg::*;

	localparam int unsigned IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PARAMS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic             esc_q;
	logic             greater_q;
	logic [IDX_W-1:0] pidx_q;
	logic [IDX_W-1:0] walk_q;
	attr_t            colour_q;
	logic [2:0]       fg_q;
	logic [2:0]       bg_q;
	logic             hi_q;
	param_t           store_q [MAX_PARAMS];

	logic    out_valid_q;
	action_t out_action_q;
	byte_t   out_byte_q;
	attr_t   out_attr_q;

	logic             out_free;
	logic             in_fire;
	byte_t            c;
	logic             is_digit;
	logic [IDX_W-1:0] rd_idx;
	param_t           rd_val;
	logic [13:0]      acc;
	param_t           digit_val;
	logic [2:0]       fg_n;
	logic [2:0]       bg_n;
	logic             hi_n;
	logic             res_now;
	action_t          res_action;
	byte_t            res_byte;
	logic             sgr_start;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign c           = in_ch.byte_in;
	assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.action    = out_action_q;
	assign out_ch.out_byte  = out_byte_q;
	assign out_ch.attribute = out_attr_q;

	// One read port on the parameter store: the walk owns it during an SGR
	// update, the digit path otherwise.
	assign rd_idx = (state_q == ST_WALK) ? walk_q : pidx_q;
	assign rd_val = store_q[rd_idx];

	always_comb begin
		acc = {1'b0, rd_val, 3'b000} + {3'b000, rd_val, 1'b0} + {10'd0, c[3:0]};
		if (rd_val == PARAM_EMPTY) begin
			digit_val = {6'd0, c[3:0]};
		end else if (acc > {4'd0, SAT_LIMIT}) begin
			digit_val = SAT_LIMIT;
		end else begin
			digit_val = acc[9:0];
		end
	end

	// Shared SGR unit: applies one stored code to the working colour.
	always_comb begin
		fg_n = fg_q;
		bg_n = bg_q;
		hi_n = hi_q;
		if (rd_val != PARAM_EMPTY) begin
			priority if ((rd_val >= SGR_FG_LO) && (rd_val <= SGR_FG_HI)) begin
				fg_n = bgr_to_rgb(3'(rd_val - SGR_FG_LO));
			end else if ((rd_val >= SGR_BG_LO) && (rd_val <= SGR_BG_HI)) begin
				bg_n = bgr_to_rgb(3'(rd_val - SGR_BG_LO));
			end else if (rd_val == SGR_BRIGHT) begin
				hi_n = 1'b1;
			end else if (rd_val == SGR_RESET) begin
				fg_n = 3'd7;
				bg_n = 3'd0;
				hi_n = 1'b0;
			end else begin
				hi_n = hi_q;
			end
		end
	end

	always_comb begin
		res_now    = 1'b0;
		res_action = ACT_PRINT;
		res_byte   = '0;
		sgr_start  = 1'b0;
		if (!esc_q) begin
			if (c == CH_BACKSPACE) begin
				res_now    = 1'b1;
				res_action = ACT_BACKSPACE;
			end else if (c != CH_ESC) begin
				res_now  = 1'b1;
				res_byte = c;
			end
		end else if ((c != CH_BRACKET) && (c != CH_GREATER) && !is_digit
			&& (c != CH_SEMICOLON) && is_alpha(c)) begin
			if (c == CH_LOWER_M) begin
				sgr_start = 1'b1;
			end else if (c == CH_UPPER_J) begin
				res_now    = 1'b1;
				res_action = ACT_CLEAR;
			end else if ((c == CH_LOWER_L) && greater_q) begin
				res_now    = 1'b1;
				res_action = ACT_CURSOR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			esc_q     <= 1'b0;
			greater_q <= 1'b0;
			pidx_q    <= '0;
			walk_q    <= '0;
			colour_q  <= ATTR_RESET;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (!esc_q) begin
							if (c == CH_ESC) begin
								esc_q     <= 1'b1;
								pidx_q    <= '0;
								greater_q <= 1'b0;
							end
						end else if (c == CH_GREATER) begin
							greater_q <= 1'b1;
						end else if ((c == CH_SEMICOLON) && (pidx_q != LAST_IDX)) begin
							pidx_q <= pidx_q + 1'b1;
						end else if ((c != CH_BRACKET) && !is_digit
							&& (c != CH_SEMICOLON)) begin
							esc_q <= 1'b0;
							if (sgr_start) begin
								state_q <= ST_WALK;
								walk_q  <= '0;
							end else begin
								pidx_q <= '0;
							end
						end
					end
				end
				ST_WALK: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == pidx_q) begin
						colour_q <= {bg_n, hi_n, fg_n};
						pidx_q   <= '0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Parameter store and working colour carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (!esc_q && (c == CH_ESC)) begin
				store_q[0] <= '0;
			end else if (esc_q && is_digit) begin
				store_q[pidx_q] <= digit_val;
			end else if (esc_q && (c == CH_SEMICOLON) && (pidx_q != LAST_IDX)) begin
				store_q[pidx_q + 1'b1] <= PARAM_EMPTY;
			end
			if (sgr_start) begin
				fg_q <= colour_q[2:0];
				hi_q <= colour_q[3];
				bg_q <= colour_q[6:4];
			end
		end else if (state_q == ST_WALK) begin
			fg_q <= fg_n;
			bg_q <= bg_n;
			hi_q <= hi_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_fire && res_now) || ((state_q == ST_EMIT) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_now) begin
			out_action_q <= res_action;
			out_byte_q   <= res_byte;
			out_attr_q   <= colour_q;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_action_q <= ACT_SET_ATTR;
			out_byte_q   <= '0;
			out_attr_q   <= colour_q;
		end
	end

`include "assert_macros.svh"

	`ASSERT_SAME(a_walk_in_range, clk, arst_n, state_q == ST_WALK, walk_q <= pidx_q)
	`ASSERT_SAME(a_byte_only_on_print, clk, arst_n,
		out_valid_q && (out_action_q != ACT_PRINT), out_byte_q == '0)
	`ASSERT_NEXT(a_sgr_starts_walk, clk, arst_n, in_fire && sgr_start,
		(state_q == ST_WALK) && !esc_q)
	`ASSERT_SAME(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE,
		!in_ch.ready && (pidx_q <= LAST_IDX))

endmodule
